// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the key filter checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/kcsf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Key case-style filter package
// Payload types, register map and key usage constants.
// ---------------------------------------------------------------------------
package kcsf_pkg;

  localparam int CONT_SLOTS = 6;
  localparam logic [2:0] MAX_CONTINUE = 3'd6;

  localparam logic [15:0] KEY_PAGE = 16'h0007;
  localparam logic [7:0] KEY_A = 8'h04;
  localparam logic [7:0] KEY_Z = 8'h1D;
  localparam logic [7:0] KEY_ONE = 8'h1E;
  localparam logic [7:0] KEY_ZERO = 8'h27;
  localparam logic [7:0] KEY_SPACE = 8'h2C;
  localparam logic [7:0] KEY_MINUS = 8'h2D;
  localparam logic [7:0] KEY_MOD_FIRST = 8'hE0;
  localparam logic [7:0] KEY_MOD_LAST = 8'hE7;
  localparam logic [7:0] LSHIFT_MOD = 8'h02;

  typedef enum logic [1:0] {
    STYLE_SNAKE = 2'd0,
    STYLE_CAMEL = 2'd1,
    STYLE_KEBAB = 2'd2
  } style_t;

  typedef enum logic [2:0] {
    CFG_CASE_STYLE = 3'd0,
    CFG_CONT_COUNT = 3'd1,
    CFG_ENTRY_0    = 3'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        action;
    logic        key_pressed;
    logic [15:0] hid_page;
    logic [7:0]  key_code;
    logic [7:0]  implicit_mods;
    logic [7:0]  explicit_mods;
  } in_t;

  typedef struct packed {
    logic [7:0] out_key_code;
    logic [7:0] out_mods;
    logic       swallowed;
    logic       mode_on;
  } out_t;

  typedef struct packed {
    logic [15:0] page;
    logic [7:0]  key;
    logic [7:0]  mods;
  } cont_entry_t;

  typedef cont_entry_t [CONT_SLOTS-1:0] cont_table_t;

endpackage

// File: src/kcsf_cont_match.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Continuation list matcher
// Compares one key event in parallel against the first count entries (count saturated at MAX_CONTINUE).
// ---------------------------------------------------------------------------
module kcsf_cont_match import kcsf_pkg::*; (
  input  cont_table_t entries,
  input  logic [2:0]  count,
  input  logic [15:0] page,
  input  logic [7:0]  key,
  input  logic [7:0]  mods,
  output logic        match
);

  logic [2:0] count_sat;
  logic [CONT_SLOTS-1:0] hit;

  assign count_sat = (count > MAX_CONTINUE) ? MAX_CONTINUE : count;

  always_comb begin
    for (int i = 0; i < CONT_SLOTS; i++) begin
      hit[i] = (3'(i) < count_sat) && (entries[i].page == page) &&
               (entries[i].key == key) && ((entries[i].mods & mods) == entries[i].mods);
    end
  end

  assign match = |hit;

endmodule

// File: src/key_case_style_filter_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Key case-style filter
// Rewrites key events for snake, camel and kebab typing modes.
// ---------------------------------------------------------------------------
// The block takes one key event per cycle while the output side is not stalled
// and returns one result per event: each event is held in the input register
// and then in the result register, where the active and pending-shift flags
// are updated as the result is loaded. Configuration registers lie at byte
// address 4*i; the user must see that they are written only while no event is
// in flight, as the block itself does not enforce it.
module key_case_style_filter_unit import kcsf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]  case_style_r;
  logic [2:0]  continue_count_r;
  cont_table_t cont_entry_r;

  logic        s0_valid_r;
  in_t         s0_data_r;
  logic        out_valid_r;
  out_t        out_data_r;
  logic        mode_r;
  logic        pend_r;

  logic        mode_nxt;
  logic        pend_nxt;
  out_t        out_data_nxt;
  logic        s0_adv;
  logic        out_load;
  logic        cont_hit;
  logic        is_mod;
  logic        is_space;
  logic        is_letter;
  logic        is_digit;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic [2:0]  entry_idx;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign cfg_idx   = paddr[4:2];
  assign entry_idx = cfg_idx - CFG_ENTRY_0;

  always_comb begin
    case (cfg_idx)
      CFG_CASE_STYLE: prdata = {30'd0, case_style_r};
      CFG_CONT_COUNT: prdata = {29'd0, continue_count_r};
      default:        prdata = cont_entry_r[entry_idx];
    endcase
  end

  assign out_load  = !out_valid_r || out_ready;
  assign s0_adv    = s0_valid_r && out_load;
  assign in_ready  = !s0_valid_r || out_load;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  kcsf_cont_match u_match (
    .entries (cont_entry_r),
    .count   (continue_count_r),
    .page    (s0_data_r.hid_page),
    .key     (s0_data_r.key_code),
    .mods    (s0_data_r.implicit_mods | s0_data_r.explicit_mods),
    .match   (cont_hit)
  );

  assign is_mod    = (s0_data_r.hid_page == KEY_PAGE) &&
                     (s0_data_r.key_code >= KEY_MOD_FIRST) &&
                     (s0_data_r.key_code <= KEY_MOD_LAST);
  assign is_space  = (s0_data_r.hid_page == KEY_PAGE) && (s0_data_r.key_code == KEY_SPACE);
  assign is_letter = (s0_data_r.key_code >= KEY_A) && (s0_data_r.key_code <= KEY_Z);
  assign is_digit  = (s0_data_r.key_code >= KEY_ONE) && (s0_data_r.key_code <= KEY_ZERO);

  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    out_data_nxt.out_key_code = s0_data_r.key_code;
    out_data_nxt.out_mods     = s0_data_r.implicit_mods;
    out_data_nxt.swallowed    = 1'b0;
    if (!s0_data_r.action) begin
      mode_nxt = !mode_r;
      pend_nxt = 1'b0;
      out_data_nxt.out_key_code = '0;
      out_data_nxt.out_mods     = '0;
      out_data_nxt.swallowed    = 1'b1;
    end else if (s0_data_r.key_pressed && mode_r && !is_mod) begin
      if (is_space) begin
        case (case_style_r)
          STYLE_SNAKE: begin
            out_data_nxt.out_key_code = KEY_MINUS;
            out_data_nxt.out_mods     = s0_data_r.implicit_mods | LSHIFT_MOD;
          end
          STYLE_CAMEL: begin
            pend_nxt = 1'b1;
            out_data_nxt.swallowed = 1'b1;
          end
          STYLE_KEBAB: begin
            out_data_nxt.out_key_code = KEY_MINUS;
          end
          default: begin
          end
        endcase
      end else if (pend_r && is_letter) begin
        out_data_nxt.out_mods = s0_data_r.implicit_mods | LSHIFT_MOD;
        pend_nxt = 1'b0;
      end else begin
        pend_nxt = 1'b0;
        if (!is_letter && !is_digit && !cont_hit) begin
          mode_nxt = 1'b0;
        end
      end
    end
    out_data_nxt.mode_on = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_style_r     <= '0;
      continue_count_r <= '0;
      cont_entry_r     <= '0;
      s0_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      mode_r           <= 1'b0;
      pend_r           <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          CFG_CASE_STYLE: case_style_r <= pwdata[1:0];
          CFG_CONT_COUNT: continue_count_r <= pwdata[2:0];
          default:        cont_entry_r[entry_idx] <= pwdata;
        endcase
      end
      if (in_ready) begin
        s0_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= s0_valid_r;
      end
      if (s0_adv) begin
        mode_r <= mode_nxt;
        pend_r <= pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_data_r <= in_data;
    end
    if (s0_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// File: src/kcsf_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Key case-style filter checker
// Port-level assertions on transfers and result contents.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kcsf_checker import kcsf_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // A stalled result stays offered.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // With no result pending the input side is always open.
  `ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

  // A swallowed event while the mode is off can only be a toggle.
  `ASSERT_IMPL(a_toggle_result, clk, rst_n, out_valid && out_data.swallowed,
               out_data.mode_on || (out_data.out_key_code == 8'd0 && out_data.out_mods == 8'd0))

  // A new result appears only after an input transfer has passed through the input register.
  `ASSERT_IMPL(a_no_invented, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind key_case_style_filter_unit kcsf_checker u_kcsf_checker (.*);

// File: test/tb_key_case_style_filter_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Key case-style filter testbench
// Drives key events and toggles through the filter under several style and
// continuation settings, predicts every result in a scoreboard, and checks
// each result transfer field by field under random sender and receiver idling.
// ---------------------------------------------------------------------------
module tb_key_case_style_filter_unit;
  import kcsf_pkg::*;

  localparam logic [1:0] STYLE_UNUSED = 2'd3;

  class case_filter_scoreboard;
    logic [1:0]  style;
    logic [2:0]  cont_count;
    cont_entry_t entries [CONT_SLOTS];
    bit          mode_active;
    bit          shift_armed;
    out_t        awaited [$];
    int          failures;

    function new();
      style = STYLE_SNAKE;
      cont_count = '0;
      foreach (entries[i]) entries[i] = '0;
      mode_active = 1'b0;
      shift_armed = 1'b0;
      failures = 0;
    endfunction

    function void load_register(int idx, logic [31:0] value);
      if (idx == CFG_CASE_STYLE) begin
        style = value[1:0];
      end else if (idx == CFG_CONT_COUNT) begin
        cont_count = value[2:0];
      end else if (idx >= CFG_ENTRY_0 && idx < CFG_ENTRY_0 + CONT_SLOTS) begin
        entries[idx - CFG_ENTRY_0] = cont_entry_t'(value);
      end
    endfunction

    function bit continues(logic [15:0] page, logic [7:0] key, logic [7:0] mods);
      int n;
      n = (cont_count > MAX_CONTINUE) ? MAX_CONTINUE : cont_count;
      for (int i = 0; i < n; i++) begin
        if (entries[i].page == page && entries[i].key == key &&
            (entries[i].mods & mods) == entries[i].mods) begin
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_event(in_t ev);
      out_t r;
      bit   is_letter;
      bit   is_digit;
      r.out_key_code = ev.key_code;
      r.out_mods = ev.implicit_mods;
      r.swallowed = 1'b0;
      is_letter = ev.key_code >= KEY_A && ev.key_code <= KEY_Z;
      is_digit = ev.key_code >= KEY_ONE && ev.key_code <= KEY_ZERO;
      if (!ev.action) begin
        mode_active = !mode_active;
        shift_armed = 1'b0;
        r.out_key_code = '0;
        r.out_mods = '0;
        r.swallowed = 1'b1;
      end else if (ev.key_pressed && mode_active &&
                   !(ev.hid_page == KEY_PAGE && ev.key_code >= KEY_MOD_FIRST &&
                     ev.key_code <= KEY_MOD_LAST)) begin
        if (ev.hid_page == KEY_PAGE && ev.key_code == KEY_SPACE) begin
          case (style)
            STYLE_SNAKE: begin
              r.out_key_code = KEY_MINUS;
              r.out_mods = ev.implicit_mods | LSHIFT_MOD;
            end
            STYLE_CAMEL: begin
              shift_armed = 1'b1;
              r.swallowed = 1'b1;
            end
            STYLE_KEBAB: begin
              r.out_key_code = KEY_MINUS;
            end
            default: begin
            end
          endcase
        end else if (shift_armed && is_letter) begin
          r.out_mods = ev.implicit_mods | LSHIFT_MOD;
          shift_armed = 1'b0;
        end else begin
          shift_armed = 1'b0;
          if (!is_letter && !is_digit &&
              !continues(ev.hid_page, ev.key_code, ev.implicit_mods | ev.explicit_mods)) begin
            mode_active = 1'b0;
          end
        end
      end
      r.mode_on = mode_active;
      awaited.push_back(r);
    endfunction

    function void report(string field, logic [7:0] want_v, logic [7:0] got_v);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
      failures++;
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result %h arrived with no transfer outstanding", $time, got);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (got.out_key_code !== want.out_key_code)
        report("key code", want.out_key_code, got.out_key_code);
      if (got.out_mods !== want.out_mods) report("mods", want.out_mods, got.out_mods);
      if (got.swallowed !== want.swallowed)
        report("swallowed", 8'(want.swallowed), 8'(got.swallowed));
      if (got.mode_on !== want.mode_on) report("mode on", 8'(want.mode_on), 8'(got.mode_on));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  case_filter_scoreboard filter_sb = new();

  key_case_style_filter_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) filter_sb.note_event(in_data);
      if (out_valid && out_ready) filter_sb.check_result(out_data);
    end
  end

  task automatic write_reg(input int idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    filter_sb.load_register(idx, value);
  endtask

  task automatic configure(input logic [1:0] style, input logic [2:0] count,
                           input cont_table_t entries_in);
    write_reg(CFG_CASE_STYLE, 32'(style));
    write_reg(CFG_CONT_COUNT, 32'(count));
    for (int i = 0; i < CONT_SLOTS; i++) write_reg(CFG_ENTRY_0 + i, entries_in[i]);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_event(input in_t ev);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (filter_sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic in_t key_event(logic [15:0] page, logic [7:0] key, logic [7:0] imods,
                                    logic [7:0] emods, logic pressed);
    in_t ev;
    ev.action = 1'b1;
    ev.key_pressed = pressed;
    ev.hid_page = page;
    ev.key_code = key;
    ev.implicit_mods = imods;
    ev.explicit_mods = emods;
    return ev;
  endfunction

  function automatic in_t toggle_event();
    in_t ev;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    ev = raw[$bits(in_t)-1:0];
    ev.action = 1'b0;
    return ev;
  endfunction

  function automatic cont_entry_t rand_entry();
    cont_entry_t e;
    e.page = $urandom_range(1) ? KEY_PAGE : 16'($urandom);
    e.key = $urandom_range(1) ? 8'($urandom_range(8'h28, 8'h38)) : 8'($urandom);
    e.mods = 8'($urandom & $urandom & $urandom);
    return e;
  endfunction

  function automatic in_t make_event();
    in_t         ev;
    cont_entry_t e;
    logic [63:0] raw;
    logic [7:0]  split;
    int          kind;
    raw = {$urandom, $urandom};
    ev = raw[$bits(in_t)-1:0];
    kind = $urandom_range(99);
    e = filter_sb.entries[$urandom_range(CONT_SLOTS - 1)];
    split = 8'($urandom);
    if (kind < 9) begin
      ev.action = 1'b0;
    end else if (kind < 88) begin
      ev.action = 1'b1;
      ev.key_pressed = (kind >= 80) ? 1'b0 : 1'b1;
      if (kind < 34) begin
        ev.key_code = 8'($urandom_range(KEY_A, KEY_Z));
        if ($urandom_range(3) != 0) ev.hid_page = KEY_PAGE;
      end else if (kind < 44) begin
        ev.key_code = 8'($urandom_range(KEY_ONE, KEY_ZERO));
        if ($urandom_range(3) != 0) ev.hid_page = KEY_PAGE;
      end else if (kind < 60) begin
        ev.hid_page = KEY_PAGE;
        ev.key_code = KEY_SPACE;
      end else if (kind < 66) begin
        ev.hid_page = KEY_PAGE;
        ev.key_code = 8'($urandom_range(KEY_MOD_FIRST, KEY_MOD_LAST));
      end else if (kind < 76) begin
        ev.hid_page = e.page;
        ev.key_code = e.key;
        ev.implicit_mods = ev.implicit_mods | (e.mods & split);
        ev.explicit_mods = ev.explicit_mods | (e.mods & ~split);
      end else if (kind < 80) begin
        ev.hid_page = e.page;
        ev.key_code = e.key;
        split = 8'(1 << $urandom_range(7));
        ev.implicit_mods = e.mods & ~split;
        ev.explicit_mods = e.mods & ~split;
      end
    end
    return ev;
  endfunction

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    cont_table_t tbl;
    in_t         directed [$];
    logic [1:0]  style_plan [8];
    logic [2:0]  count_plan [8];
    int          guard;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    style_plan = '{STYLE_SNAKE, STYLE_CAMEL, STYLE_KEBAB, STYLE_UNUSED,
                   STYLE_CAMEL, STYLE_SNAKE, STYLE_KEBAB, STYLE_CAMEL};
    count_plan = '{3'd6, 3'd7, 3'd0, 3'd3, 3'd6, 3'd1, 3'd7, 3'd5};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tbl = '0;
    tbl[0] = {KEY_PAGE, KEY_MINUS, LSHIFT_MOD};
    tbl[1] = '1;
    configure(STYLE_SNAKE, 3'd2, tbl);
    directed.push_back(key_event(KEY_PAGE, KEY_SPACE, 8'h00, 8'h00, 1'b1));
    directed.push_back('{action: 1'b0, key_pressed: 1'b1, hid_page: '1, key_code: '1,
                         implicit_mods: '1, explicit_mods: '1});
    directed.push_back(key_event(KEY_PAGE, KEY_SPACE, 8'h81, 8'h00, 1'b1));
    directed.push_back(key_event(16'hFFFF, KEY_A, 8'hFF, 8'h00, 1'b1));
    directed.push_back(key_event(16'h0000, KEY_Z, 8'h00, 8'hFF, 1'b1));
    directed.push_back(key_event(KEY_PAGE, KEY_ONE, 8'h00, 8'h00, 1'b1));
    directed.push_back(key_event(KEY_PAGE, KEY_ZERO, 8'h00, 8'h00, 1'b1));
    directed.push_back(key_event(KEY_PAGE, KEY_MOD_FIRST, 8'h00, 8'h00, 1'b1));
    directed.push_back(key_event(KEY_PAGE, KEY_MOD_LAST, 8'h00, 8'h00, 1'b1));
    directed.push_back(key_event(KEY_PAGE, 8'h38, 8'h00, 8'h00, 1'b0));
    directed.push_back(key_event(KEY_PAGE, KEY_MINUS, 8'h00, LSHIFT_MOD, 1'b1));
    directed.push_back(key_event(16'hFFFF, 8'hFF, 8'hF0, 8'h0F, 1'b1));
    directed.push_back(key_event(16'hFFFF, 8'hFF, 8'h7F, 8'h00, 1'b1));
    directed.push_back(toggle_event());
    directed.push_back(key_event(KEY_PAGE, 8'h03, 8'h00, 8'h00, 1'b1));
    directed.push_back(toggle_event());
    directed.push_back(key_event(16'h0008, KEY_MOD_FIRST, 8'h00, 8'h00, 1'b1));
    foreach (directed[i]) send_event(directed[i]);
    drain();

    configure(STYLE_CAMEL, 3'd0, '0);
    directed = {};
    directed.push_back(toggle_event());
    directed.push_back(key_event(KEY_PAGE, KEY_SPACE, 8'h00, 8'h00, 1'b1));
    directed.push_back(key_event(KEY_PAGE, 8'h10, 8'h00, 8'h00, 1'b1));
    directed.push_back(key_event(KEY_PAGE, KEY_SPACE, 8'h00, 8'h00, 1'b1));
    directed.push_back(key_event(KEY_PAGE, 8'h20, 8'h00, 8'h00, 1'b1));
    directed.push_back(key_event(KEY_PAGE, 8'h11, 8'h00, 8'h00, 1'b1));
    directed.push_back(key_event(KEY_PAGE, KEY_SPACE, 8'h00, 8'h00, 1'b1));
    directed.push_back(toggle_event());
    directed.push_back(toggle_event());
    directed.push_back(key_event(KEY_PAGE, 8'h12, 8'h00, 8'h00, 1'b1));
    directed.push_back(key_event(KEY_PAGE, KEY_SPACE, 8'h00, 8'h00, 1'b1));
    directed.push_back(key_event(KEY_PAGE, 8'h28, 8'h00, 8'h00, 1'b1));
    foreach (directed[i]) send_event(directed[i]);
    drain();

    configure(STYLE_KEBAB, 3'd0, '0);
    send_event(toggle_event());
    send_event(key_event(KEY_PAGE, KEY_SPACE, 8'h00, 8'h00, 1'b1));
    drain();
    configure(STYLE_UNUSED, 3'd0, '0);
    send_event(key_event(KEY_PAGE, KEY_SPACE, 8'h00, 8'h00, 1'b1));
    send_event(key_event(KEY_PAGE, 8'h38, 8'h00, 8'h00, 1'b1));
    drain();

    for (int p = 0; p < 8; p++) begin
      for (int i = 0; i < CONT_SLOTS; i++) begin
        if (p == 3) tbl[i] = '0;
        else if (p == 5) tbl[i] = '1;
        else tbl[i] = rand_entry();
      end
      configure(style_plan[p], count_plan[p], tbl);
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 70;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 70;
        end
        default: begin
          sender_idle_pct = 37;
          receiver_stall_pct = 37;
        end
      endcase
      for (int n = 0; n < 156; n++) begin
        send_event(make_event());
        if (n == 60 || $urandom_range(199) == 0) drain();
      end
      drain();
    end

    receiver_stall_pct = 0;
    guard = 0;
    while (filter_sb.awaited.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (filter_sb.awaited.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, filter_sb.awaited.size());
      filter_sb.failures++;
    end
    if (filter_sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
